// ===== rtl/ipns_pkg.sv =====
// ----------------------------------------------------------------------------
// ipns_pkg
// Shared constants, types and helpers of the isolated pixel neighbor smoother.
// ----------------------------------------------------------------------------
package ipns_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int NUM_ROWS   = 3;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int COL_W      = 6;
  localparam int WCNT_W     = $clog2(LINE_DEPTH + 1);
  localparam int ROW_W      = 10;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int MIN_DIM    = 2;

  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_MUL_W = 10;
  localparam int PROD_W     = SUM_W + DIV3_MUL_W;

  localparam logic [COL_W-1:0] RST_FRAME_WIDTH    = 6'd30;
  localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT   = 10'd20;
  localparam logic [PIX_W-1:0] RST_DIFF_THRESHOLD = 8'd1;
  localparam logic [PIX_W-1:0] GLYPH_OFFSET       = 8'd33;

  typedef logic [1:0] slot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DIFF_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_BY_2,
    DIV_BY_3,
    DIV_BY_4
  } div_sel_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    slot_t            slot;
    logic             emit;
    logic             has_up;
    logic             has_left;
    logic             has_right;
    logic             row_end;
    logic             flush;
  } cmd_t;

  typedef struct packed {
    logic [WCNT_W-1:0] eff_width;
    logic [PIX_W-1:0]  threshold;
  } geom_t;

  function automatic slot_t slot_next(slot_t s);
    return (s == slot_t'(NUM_ROWS - 1)) ? slot_t'(0) : s + slot_t'(1);
  endfunction

  function automatic slot_t slot_prev(slot_t s);
    return (s == slot_t'(0)) ? slot_t'(NUM_ROWS - 1) : s - slot_t'(1);
  endfunction

endpackage

// ===== rtl/ipns_if.sv =====
// ----------------------------------------------------------------------------
// ipns_if
// Valid/ready channels of the smoother: pixel input, result output and
// register writes.
// ----------------------------------------------------------------------------
interface ipns_pix_if;
  logic                       valid;
  logic                       ready;
  logic [ipns_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface ipns_res_if;
  logic                       valid;
  logic                       ready;
  logic [ipns_pkg::PIX_W-1:0] pixel_out;
  logic [ipns_pkg::PIX_W-1:0] glyph_code;
  logic                       row_end;
  logic                       last;

  modport source (output valid, output pixel_out, output glyph_code, output row_end,
                  output last, input ready);
  modport sink (input valid, input pixel_out, input glyph_code, input row_end,
                input last, output ready);
endinterface

interface ipns_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ipns_pkg::CFG_IDX_W-1:0]  index;
  logic [ipns_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ipns_ram.sv =====
// ----------------------------------------------------------------------------
// ipns_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ipns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

// ===== rtl/ipns_front.sv =====
// ----------------------------------------------------------------------------
// ipns_front
// Register file and raster position tracking; turns each input pixel into a
// command for the filter back end.
// ----------------------------------------------------------------------------
module ipns_front (
  input  logic            clk,
  input  logic            rst_n,
  ipns_pix_if.sink        in_chan,
  ipns_cfg_if.sink        cfg_chan,
  input  logic            q_full,
  output logic            q_push,
  output ipns_pkg::cmd_t  q_cmd,
  output ipns_pkg::geom_t geom
);

  logic [ipns_pkg::COL_W-1:0]  frame_width_r;
  logic [ipns_pkg::ROW_W-1:0]  frame_height_r;
  logic [ipns_pkg::PIX_W-1:0]  diff_threshold_r;
  logic [ipns_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [ipns_pkg::ROW_W-1:0]  row_r, row_nxt;
  ipns_pkg::slot_t             slot_r, slot_nxt;
  logic [ipns_pkg::WCNT_W-1:0] eff_w;
  logic [ipns_pkg::ROW_W-1:0]  eff_h;
  logic [ipns_pkg::COL_W-1:0]  cur_col;
  logic [ipns_pkg::ROW_W-1:0]  cur_row;
  ipns_pkg::slot_t             cur_slot;
  logic [ipns_pkg::WCNT_W-1:0] col_plus1;
  logic [ipns_pkg::ROW_W-1:0]  row_plus1;
  logic                        row_end;
  logic                        frame_end;
  logic                        accept;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !q_full;
  assign accept         = in_chan.valid && !q_full;
  assign q_push         = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= ipns_pkg::RST_FRAME_WIDTH;
      frame_height_r   <= ipns_pkg::RST_FRAME_HEIGHT;
      diff_threshold_r <= ipns_pkg::RST_DIFF_THRESHOLD;
    end else if (cfg_chan.valid) begin
      unique case (ipns_pkg::cfg_reg_t'(cfg_chan.index))
        ipns_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_chan.data[ipns_pkg::COL_W-1:0];
        end
        ipns_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_chan.data[ipns_pkg::ROW_W-1:0];
        end
        ipns_pkg::REG_DIFF_THRESHOLD: begin
          diff_threshold_r <= cfg_chan.data[ipns_pkg::PIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (int'(frame_width_r) < ipns_pkg::MIN_DIM) begin
      eff_w = ipns_pkg::WCNT_W'(ipns_pkg::MIN_DIM);
    end else if (int'(frame_width_r) > ipns_pkg::LINE_DEPTH) begin
      eff_w = ipns_pkg::WCNT_W'(ipns_pkg::LINE_DEPTH);
    end else begin
      eff_w = ipns_pkg::WCNT_W'(frame_width_r);
    end
    if (int'(frame_height_r) < ipns_pkg::MIN_DIM) begin
      eff_h = ipns_pkg::ROW_W'(ipns_pkg::MIN_DIM);
    end else begin
      eff_h = frame_height_r;
    end
  end

  assign geom.eff_width = eff_w;
  assign geom.threshold = diff_threshold_r;

  // A geometry change between frames can leave the position outside the
  // frame, so the position is brought back inside before it is used.
  always_comb begin
    cur_col  = col_r;
    cur_row  = row_r;
    cur_slot = slot_r;
    if (int'(col_r) >= int'(eff_w)) begin
      cur_col  = '0;
      cur_row  = row_r + ipns_pkg::ROW_W'(1);
      cur_slot = ipns_pkg::slot_next(slot_r);
    end
    if (cur_row >= eff_h) begin
      cur_row  = '0;
      cur_slot = '0;
    end

    col_plus1 = ipns_pkg::WCNT_W'(cur_col) + ipns_pkg::WCNT_W'(1);
    row_plus1 = cur_row + ipns_pkg::ROW_W'(1);
    row_end   = (col_plus1 == eff_w);
    frame_end = row_end && (row_plus1 == eff_h);

    q_cmd.pixel     = in_chan.pixel_in;
    q_cmd.col       = cur_col;
    q_cmd.slot      = cur_slot;
    q_cmd.emit      = (cur_row != '0);
    q_cmd.has_up    = (cur_row > ipns_pkg::ROW_W'(1));
    q_cmd.has_left  = (cur_col != '0);
    q_cmd.has_right = !row_end;
    q_cmd.row_end   = row_end;
    q_cmd.flush     = frame_end;

    if (row_end) begin
      col_nxt = '0;
      if (frame_end) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_plus1;
        slot_nxt = ipns_pkg::slot_next(cur_slot);
      end
    end else begin
      col_nxt  = ipns_pkg::COL_W'(col_plus1);
      row_nxt  = cur_row;
      slot_nxt = cur_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

// ===== rtl/ipns_fifo.sv =====
// ----------------------------------------------------------------------------
// ipns_fifo
// Short command queue between the front end and the filter back end.
// ----------------------------------------------------------------------------
module ipns_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ipns_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output ipns_pkg::cmd_t pop_data,
  output logic           empty
);

  ipns_pkg::cmd_t               mem_r [ipns_pkg::FIFO_DEPTH];
  logic [ipns_pkg::FIFO_AW-1:0] wptr_r;
  logic [ipns_pkg::FIFO_AW-1:0] rptr_r;
  logic [ipns_pkg::FIFO_AW:0]   count_r, count_nxt;

  assign full     = (count_r == (ipns_pkg::FIFO_AW + 1)'(ipns_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + (ipns_pkg::FIFO_AW + 1)'(1);
      2'b01:   count_nxt = count_r - (ipns_pkg::FIFO_AW + 1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  // The depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + ipns_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + ipns_pkg::FIFO_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/ipns_back.sv =====
// ----------------------------------------------------------------------------
// ipns_back
// Filter back end: three row buffers, neighbor compare and mean, output
// register, and the sequencer that flushes the final row of a frame.
// ----------------------------------------------------------------------------
module ipns_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  ipns_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  input  ipns_pkg::geom_t geom,
  ipns_res_if.source      out_chan
);

  typedef struct packed {
    logic                       valid;
    ipns_pkg::slot_t            slot_c;
    ipns_pkg::slot_t            slot_u;
    logic                       has_up;
    logic                       has_down;
    logic                       has_left;
    logic                       has_right;
    logic [ipns_pkg::PIX_W-1:0] down;
    logic                       row_end;
    logic                       last;
  } stage_a_t;

  typedef struct packed {
    logic                       valid;
    logic [ipns_pkg::PIX_W-1:0] centre;
    logic [ipns_pkg::SUM_W-1:0] sum;
    logic                       all_far;
    ipns_pkg::div_sel_t         div_sel;
    logic                       row_end;
    logic                       last;
  } stage_b_t;

  logic                        adv;
  logic                        ram_wr;
  logic [ipns_pkg::NUM_ROWS-1:0] ram_we;
  logic [ipns_pkg::COL_W-1:0]  rd_col;
  logic [ipns_pkg::COL_W-1:0]  rd_col_p1;
  logic [ipns_pkg::PIX_W-1:0]  rd_a [ipns_pkg::NUM_ROWS];
  logic [ipns_pkg::PIX_W-1:0]  rd_b [ipns_pkg::NUM_ROWS];
  logic                        flushing_r, flushing_nxt;
  logic [ipns_pkg::COL_W-1:0]  fl_col_r, fl_col_nxt;
  ipns_pkg::slot_t             fl_slot_r, fl_slot_nxt;
  logic [ipns_pkg::WCNT_W-1:0] fl_col_p1;
  stage_a_t                    a_r, a_nxt;
  stage_b_t                    b_r, b_nxt;
  logic [ipns_pkg::PIX_W-1:0]  prev_centre_r;
  logic [ipns_pkg::PIX_W-1:0]  centre;
  logic [ipns_pkg::PIX_W-1:0]  nb [4];
  logic [3:0]                  present;
  logic [3:0]                  near;
  logic [ipns_pkg::PIX_W-1:0]  diff [4];
  logic [ipns_pkg::SUM_W-1:0]  sum;
  logic [2:0]                  nb_cnt;
  logic [ipns_pkg::PROD_W-1:0] prod;
  logic [ipns_pkg::PIX_W-1:0]  avg;
  logic [ipns_pkg::PIX_W-1:0]  res_pix;
  logic                        out_valid_r;
  logic [ipns_pkg::PIX_W-1:0]  out_pix_r;
  logic                        out_row_end_r;
  logic                        out_last_r;

  assign adv = !out_valid_r || out_chan.ready;

  always_comb begin
    q_pop        = 1'b0;
    ram_wr       = 1'b0;
    flushing_nxt = flushing_r;
    fl_col_nxt   = fl_col_r;
    fl_slot_nxt  = fl_slot_r;
    rd_col       = q_cmd.col;
    fl_col_p1    = ipns_pkg::WCNT_W'(fl_col_r) + ipns_pkg::WCNT_W'(1);
    a_nxt        = '0;
    if (adv) begin
      if (flushing_r) begin
        rd_col          = fl_col_r;
        a_nxt.valid     = 1'b1;
        a_nxt.slot_c    = fl_slot_r;
        a_nxt.slot_u    = ipns_pkg::slot_prev(fl_slot_r);
        a_nxt.has_up    = 1'b1;
        a_nxt.has_down  = 1'b0;
        a_nxt.has_left  = (fl_col_r != '0);
        a_nxt.has_right = (fl_col_p1 < geom.eff_width);
        a_nxt.row_end   = (fl_col_p1 >= geom.eff_width);
        a_nxt.last      = a_nxt.row_end;
        if (a_nxt.row_end) begin
          flushing_nxt = 1'b0;
          fl_col_nxt   = '0;
        end else begin
          fl_col_nxt = ipns_pkg::COL_W'(fl_col_p1);
        end
      end else if (!q_empty) begin
        q_pop           = 1'b1;
        ram_wr          = 1'b1;
        a_nxt.valid     = q_cmd.emit;
        a_nxt.slot_c    = ipns_pkg::slot_prev(q_cmd.slot);
        a_nxt.slot_u    = ipns_pkg::slot_next(q_cmd.slot);
        a_nxt.has_up    = q_cmd.has_up;
        a_nxt.has_down  = 1'b1;
        a_nxt.has_left  = q_cmd.has_left;
        a_nxt.has_right = q_cmd.has_right;
        a_nxt.down      = q_cmd.pixel;
        a_nxt.row_end   = q_cmd.row_end;
        a_nxt.last      = 1'b0;
        if (q_cmd.flush) begin
          flushing_nxt = 1'b1;
          fl_col_nxt   = '0;
          fl_slot_nxt  = q_cmd.slot;
        end
      end
    end
    rd_col_p1 = rd_col + ipns_pkg::COL_W'(1);
    for (int i = 0; i < ipns_pkg::NUM_ROWS; i++) begin
      ram_we[i] = ram_wr && (q_cmd.slot == ipns_pkg::slot_t'(i));
    end
  end

  for (genvar g = 0; g < ipns_pkg::NUM_ROWS; g++) begin : g_row
    ipns_ram #(
      .WIDTH(ipns_pkg::PIX_W),
      .DEPTH(ipns_pkg::LINE_DEPTH)
    ) u_ram (
      .clk     (clk),
      .we      (ram_we[g]),
      .waddr   (q_cmd.col[ipns_pkg::ADDR_W-1:0]),
      .wdata   (q_cmd.pixel),
      .re      (adv),
      .raddr_a (rd_col[ipns_pkg::ADDR_W-1:0]),
      .raddr_b (rd_col_p1[ipns_pkg::ADDR_W-1:0]),
      .rdata_a (rd_a[g]),
      .rdata_b (rd_b[g])
    );
  end

  // The left neighbor is the center of the item just before in the same row.
  always_comb begin
    centre  = rd_a[a_r.slot_c];
    nb[0]   = rd_a[a_r.slot_u];
    nb[1]   = a_r.down;
    nb[2]   = prev_centre_r;
    nb[3]   = rd_b[a_r.slot_c];
    present = {a_r.has_right, a_r.has_left, a_r.has_down, a_r.has_up};
    sum     = '0;
    for (int i = 0; i < 4; i++) begin
      diff[i] = (centre > nb[i]) ? centre - nb[i] : nb[i] - centre;
      near[i] = present[i] && (diff[i] <= geom.threshold);
      if (present[i]) begin
        sum = sum + ipns_pkg::SUM_W'(nb[i]);
      end
    end
    nb_cnt = 3'($countones(present));

    b_nxt.valid   = a_r.valid;
    b_nxt.centre  = centre;
    b_nxt.sum     = sum;
    b_nxt.all_far = (near == '0);
    b_nxt.row_end = a_r.row_end;
    b_nxt.last    = a_r.last;
    unique case (nb_cnt)
      3'd4:    b_nxt.div_sel = ipns_pkg::DIV_BY_4;
      3'd3:    b_nxt.div_sel = ipns_pkg::DIV_BY_3;
      default: b_nxt.div_sel = ipns_pkg::DIV_BY_2;
    endcase
  end

  // Division by three is a multiply by 683/2048, exact for sums up to 765.
  always_comb begin
    prod = ipns_pkg::PROD_W'(b_r.sum) * ipns_pkg::PROD_W'(ipns_pkg::DIV3_MUL);
    unique case (b_r.div_sel)
      ipns_pkg::DIV_BY_4: avg = b_r.sum[ipns_pkg::PIX_W+1:2];
      ipns_pkg::DIV_BY_3: avg = prod[ipns_pkg::DIV3_SHIFT +: ipns_pkg::PIX_W];
      default:            avg = b_r.sum[ipns_pkg::PIX_W:1];
    endcase
    res_pix = b_r.all_far ? avg : b_r.centre;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flushing_r  <= 1'b0;
      fl_col_r    <= '0;
      fl_slot_r   <= '0;
      a_r.valid   <= 1'b0;
      b_r.valid   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      flushing_r <= flushing_nxt;
      fl_col_r   <= fl_col_nxt;
      fl_slot_r  <= fl_slot_nxt;
      if (adv) begin
        a_r         <= a_nxt;
        b_r         <= b_nxt;
        out_valid_r <= b_r.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r     <= res_pix;
      out_row_end_r <= b_r.row_end;
      out_last_r    <= b_r.last;
      if (a_r.valid) begin
        prev_centre_r <= centre;
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.pixel_out  = out_pix_r;
  assign out_chan.glyph_code = out_pix_r + ipns_pkg::GLYPH_OFFSET;
  assign out_chan.row_end    = out_row_end_r;
  assign out_chan.last       = out_last_r;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n) flushing_r |-> !q_pop)
    else $error("Command taken from the queue during a final row flush.");

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("Command taken from an empty queue.");

  assert property (@(posedge clk) disable iff (!rst_n)
    flushing_r |-> (int'(fl_col_r) < int'(geom.eff_width)))
    else $error("Flush column ran past the frame width.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_row_end_r)
    else $error("Frame end item does not close a row.");
`endif

endmodule

// ===== rtl/isolated_pixel_neighbor_smoother.sv =====
// ----------------------------------------------------------------------------
// isolated_pixel_neighbor_smoother
// Replaces pixels that differ from all their 4-neighbors by more than a
// threshold with the truncated mean of those neighbors; results run one row
// behind the input and the last pixel of a frame flushes the final row.
//
//   Channel    Direction  Payload
//   in_chan    sink       pixel_in
//   out_chan   source     pixel_out, glyph_code, row_end, last
//   cfg_chan   sink       index, data (frame_width, frame_height, diff_threshold)
//
// One pixel is accepted per cycle while the queue has room; each result then
// passes through the registered row buffer read, the compare stage register
// and the output register.
// The last pixel of a frame adds a flush, one result per unstalled cycle, for
// the effective frame width; input stalls once the four-entry queue is full.
// A stalled output holds the whole back end; the four-entry queue decouples it.
// Reset clears the position counters and loads the register defaults; the row
// buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module isolated_pixel_neighbor_smoother (
  input logic         clk,
  input logic         rst_n,
  ipns_pix_if.sink    in_chan,
  ipns_res_if.source  out_chan,
  ipns_cfg_if.sink    cfg_chan
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  ipns_pkg::cmd_t  push_cmd;
  ipns_pkg::cmd_t  pop_cmd;
  ipns_pkg::geom_t geom;

  ipns_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .geom     (geom)
  );

  ipns_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .empty     (q_empty)
  );

  ipns_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .geom     (geom),
    .out_chan (out_chan)
  );

endmodule

// ===== tb/isolated_pixel_neighbor_smoother_test.sv =====
// ----------------------------------------------------------------------------
// isolated_pixel_neighbor_smoother_test
// Streams raster frames through the smoother. A built-in predictor keeps its
// own three-row pixel store and frame position and queues the smoothed pixels
// that each accepted item releases. Every result is checked field by field.
// A short directed set covers corners, edges, interior pixels, clamped geometry
// and a row closed early by a narrower width. Random segments follow, made of
// whole frames, frames cut short by a lower height or width, and threshold
// changes within a frame, under four patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module isolated_pixel_neighbor_smoother_test;

  typedef struct packed {
    logic [ipns_pkg::PIX_W-1:0] pixel;
    logic [ipns_pkg::PIX_W-1:0] glyph;
    logic                       row_end;
    logic                       last;
  } smoothed_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;
  typedef enum int {PIX_UNIFORM, PIX_IMPULSE} pix_style_t;
  typedef enum int {SEG_WIDEST, SEG_FULL, SEG_HEIGHT_CUT, SEG_WIDTH_CUT, SEG_THRESH_CHANGE}
    segment_t;

  localparam logic [ipns_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 180;
  localparam int MIN_SEGMENTS  = 4;
  localparam int MAX_WIDTH     = 63;
  localparam int MAX_HEIGHT    = 1023;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ipns_pix_if in_chan();
  ipns_res_if out_chan();
  ipns_cfg_if cfg_chan();

  isolated_pixel_neighbor_smoother dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  logic [ipns_pkg::PIX_W-1:0] row_mem [ipns_pkg::NUM_ROWS*ipns_pkg::LINE_DEPTH];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      frame_width_q;
  int unsigned      frame_height_q;
  int unsigned      threshold_q;

  logic [ipns_pkg::PIX_W-1:0] raw_pixels [$];
  smoothed_t        smoothed_due [$];

  bit          in_busy;
  bit          in_taken;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned pixels_queued;
  int unsigned pixels_taken;
  int unsigned results_seen;
  int unsigned cfg_writes;
  int unsigned mismatches;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [ipns_pkg::PIX_W-1:0] stored_pixel(int unsigned row,
                                                              int unsigned col);
    return row_mem[(row % ipns_pkg::NUM_ROWS) * ipns_pkg::LINE_DEPTH
                   + (col % ipns_pkg::LINE_DEPTH)];
  endfunction

  function automatic logic [ipns_pkg::PIX_W-1:0] smoothed_at(int unsigned row,
                                                             int unsigned col,
                                                             int unsigned width,
                                                             bit has_down);
    int unsigned centre;
    int unsigned nb [4];
    int unsigned n;
    int unsigned sum;
    int unsigned d;
    bit          all_far;
    centre  = 32'(stored_pixel(row, col));
    n       = 0;
    sum     = 0;
    all_far = 1'b1;
    if (row >= 1) begin
      nb[n] = 32'(stored_pixel(row - 1, col));
      n++;
    end
    if (has_down) begin
      nb[n] = 32'(stored_pixel(row + 1, col));
      n++;
    end
    if (col >= 1) begin
      nb[n] = 32'(stored_pixel(row, col - 1));
      n++;
    end
    if (col + 1 < width) begin
      nb[n] = 32'(stored_pixel(row, col + 1));
      n++;
    end
    for (int i = 0; i < n; i++) begin
      d = (centre > nb[i]) ? centre - nb[i] : nb[i] - centre;
      if (d <= threshold_q) all_far = 1'b0;
      sum += nb[i];
    end
    if (n == 0 || !all_far) return ipns_pkg::PIX_W'(centre);
    return ipns_pkg::PIX_W'(sum / n);
  endfunction

  function automatic void queue_smoothed(logic [ipns_pkg::PIX_W-1:0] pix, bit row_end,
                                         bit last);
    smoothed_t s;
    s.pixel   = pix;
    s.glyph   = pix + ipns_pkg::GLYPH_OFFSET;
    s.row_end = row_end;
    s.last    = last;
    smoothed_due.push_back(s);
  endfunction

  function automatic void predict_pixel(logic [ipns_pkg::PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    w = (frame_width_q < ipns_pkg::MIN_DIM) ? ipns_pkg::MIN_DIM : frame_width_q;
    if (w > ipns_pkg::LINE_DEPTH) w = ipns_pkg::LINE_DEPTH;
    h = (frame_height_q < ipns_pkg::MIN_DIM) ? ipns_pkg::MIN_DIM : frame_height_q;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) % (1 << ipns_pkg::ROW_W);
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    row_mem[(r % ipns_pkg::NUM_ROWS) * ipns_pkg::LINE_DEPTH + c] = pix;
    if (r >= 1) queue_smoothed(smoothed_at(r - 1, c, w, 1'b1), c + 1 == w, 1'b0);
    if (r + 1 == h && c + 1 == w) begin
      for (int j = 0; j < w; j++) begin
        queue_smoothed(smoothed_at(r, j, w, 1'b0), j + 1 == w, j + 1 == w);
      end
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void check_field(string name, logic [ipns_pkg::PIX_W-1:0] got,
                                      logic [ipns_pkg::PIX_W-1:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                              results_seen, name, want, got));
    end
  endfunction

  always @(posedge clk) begin
    smoothed_t want;
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        cfg_writes++;
        case (cfg_chan.index)
          ipns_pkg::REG_FRAME_WIDTH:
            frame_width_q = 32'(cfg_chan.data[ipns_pkg::COL_W-1:0]);
          ipns_pkg::REG_FRAME_HEIGHT:
            frame_height_q = 32'(cfg_chan.data[ipns_pkg::ROW_W-1:0]);
          ipns_pkg::REG_DIFF_THRESHOLD:
            threshold_q = 32'(cfg_chan.data[ipns_pkg::PIX_W-1:0]);
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        predict_pixel(in_chan.pixel_in);
        pixels_taken++;
        in_taken = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (smoothed_due.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing due: pixel %0d",
                                  results_seen, out_chan.pixel_out));
        end else begin
          want = smoothed_due.pop_front();
          check_field("pixel_out", out_chan.pixel_out, want.pixel);
          check_field("glyph_code", out_chan.glyph_code, want.glyph);
          check_field("row_end", ipns_pkg::PIX_W'(out_chan.row_end),
                      ipns_pkg::PIX_W'(want.row_end));
          check_field("last", ipns_pkg::PIX_W'(out_chan.last), ipns_pkg::PIX_W'(want.last));
        end
        results_seen++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_busy || in_taken) begin
      in_busy  = 1'b0;
      in_taken = 1'b0;
      if (raw_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_chan.pixel_in <= raw_pixels.pop_front();
        in_chan.valid    <= 1'b1;
        in_busy = 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idling(idling_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 64;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 64;
      end
      default: begin
        send_idle_pct  = 15;
        recv_stall_pct = 15;
      end
    endcase
  endtask

  task automatic write_reg(logic [ipns_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    logic [ipns_pkg::CFG_DATA_W-1:0] d;
    d = ipns_pkg::CFG_DATA_W'(value);
    if (idx == ipns_pkg::REG_FRAME_WIDTH) begin
      d[ipns_pkg::CFG_DATA_W-1:ipns_pkg::COL_W] =
        (ipns_pkg::CFG_DATA_W - ipns_pkg::COL_W)'($urandom_range(15));
    end
    if (idx == ipns_pkg::REG_DIFF_THRESHOLD) begin
      d[ipns_pkg::CFG_DATA_W-1:ipns_pkg::PIX_W] =
        (ipns_pkg::CFG_DATA_W - ipns_pkg::PIX_W)'($urandom_range(3));
    end
    if (idx == REG_UNMAPPED) d = ipns_pkg::CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= d;
    do @(posedge clk); while (!(cfg_chan.valid && cfg_chan.ready));
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic feed(int n, pix_style_t style);
    int base;
    int v;
    base = int'($urandom_range(255));
    repeat (n) begin
      if (style == PIX_UNIFORM || $urandom_range(99) < 15) begin
        v = int'($urandom_range(255));
      end else begin
        v = base + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      raw_pixels.push_back(ipns_pkg::PIX_W'(v));
      pixels_queued++;
    end
  endtask

  task automatic settle();
    while (raw_pixels.size() != 0 || in_busy || smoothed_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [ipns_pkg::PIX_W-1:0] corner_set [4];
    logic [ipns_pkg::PIX_W-1:0] square_set [9];
    int               seg;
    int               rand_start;
    int               u;
    int               w;
    int               h;
    int               t;
    int               k;
    int               r;
    int               c;
    int               n;
    pix_style_t       style;
    segment_t         kind;

    in_chan.valid    = 1'b0;
    in_chan.pixel_in = '0;
    out_chan.ready   = 1'b0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.index   = '0;
    cfg_chan.data    = '0;
    col_pos          = 0;
    row_pos          = 0;
    frame_width_q    = 32'(ipns_pkg::RST_FRAME_WIDTH);
    frame_height_q   = 32'(ipns_pkg::RST_FRAME_HEIGHT);
    threshold_q      = 32'(ipns_pkg::RST_DIFF_THRESHOLD);
    set_idling(IDLE_NONE);

    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Clamped widths and heights give a two by two frame of corners only.
    corner_set = '{8'd0, 8'd255, 8'd255, 8'd0};
    write_reg(ipns_pkg::REG_FRAME_WIDTH, 1);
    write_reg(ipns_pkg::REG_FRAME_HEIGHT, 0);
    write_reg(ipns_pkg::REG_DIFF_THRESHOLD, 0);
    foreach (corner_set[i]) raw_pixels.push_back(corner_set[i]);
    pixels_queued += 4;
    settle();

    corner_set = '{8'd255, 8'd0, 8'd0, 8'd255};
    write_reg(ipns_pkg::REG_FRAME_WIDTH, 0);
    write_reg(ipns_pkg::REG_FRAME_HEIGHT, 1);
    write_reg(ipns_pkg::REG_DIFF_THRESHOLD, 255);
    foreach (corner_set[i]) raw_pixels.push_back(corner_set[i]);
    pixels_queued += 4;
    settle();

    square_set = '{8'd10, 8'd12, 8'd11, 8'd13, 8'd200, 8'd9, 8'd10, 8'd90, 8'd12};
    write_reg(REG_UNMAPPED, 0);
    write_reg(ipns_pkg::REG_FRAME_WIDTH, 3);
    write_reg(ipns_pkg::REG_FRAME_HEIGHT, 3);
    write_reg(ipns_pkg::REG_DIFF_THRESHOLD, 1);
    foreach (square_set[i]) raw_pixels.push_back(square_set[i]);
    pixels_queued += 9;
    settle();

    // A narrower width in the middle of a row closes that row early.
    write_reg(ipns_pkg::REG_FRAME_WIDTH, 4);
    write_reg(ipns_pkg::REG_DIFF_THRESHOLD, 5);
    feed(6, PIX_IMPULSE);
    settle();
    write_reg(ipns_pkg::REG_FRAME_WIDTH, 2);
    feed(2, PIX_UNIFORM);
    settle();

    rand_start = pixels_queued;
    for (seg = 0; seg < MIN_SEGMENTS || pixels_queued - rand_start < RANDOM_ITEMS; seg++) begin
      set_idling(idling_t'(seg % 4));
      style = $urandom_range(1) ? PIX_IMPULSE : PIX_UNIFORM;
      u = $urandom_range(99);
      if (seg == 0) kind = SEG_WIDEST;
      else if (u < 55) kind = SEG_FULL;
      else if (u < 70) kind = SEG_HEIGHT_CUT;
      else if (u < 85) kind = SEG_WIDTH_CUT;
      else kind = SEG_THRESH_CHANGE;

      w = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(2, 8);
      h = $urandom_range(2, 5);
      u = $urandom_range(99);
      if (u < 10) t = $urandom_range(1) * 255;
      else if (u < 55) t = $urandom_range(12);
      else t = $urandom_range(255);
      case (kind)
        SEG_WIDEST: begin
          w = MAX_WIDTH;
          h = 2;
        end
        SEG_HEIGHT_CUT: h = $urandom_range(1) ? MAX_HEIGHT : $urandom_range(6, MAX_HEIGHT - 1);
        SEG_WIDTH_CUT:  w = $urandom_range(3, 8);
        default: ;
      endcase
      write_reg(ipns_pkg::REG_FRAME_WIDTH, w);
      write_reg(ipns_pkg::REG_FRAME_HEIGHT, h);
      write_reg(ipns_pkg::REG_DIFF_THRESHOLD, t);

      case (kind)
        SEG_HEIGHT_CUT: begin
          // A height at or below the current row restarts the frame at row zero.
          k = $urandom_range(2, 4);
          feed(k * w, style);
          settle();
          n = $urandom_range(k);
          write_reg(ipns_pkg::REG_FRAME_HEIGHT, n);
          feed(w * ((n < ipns_pkg::MIN_DIM) ? ipns_pkg::MIN_DIM : n), style);
        end
        SEG_WIDTH_CUT: begin
          // The cut row is never the last one, so the frame still ends in a flush.
          r = $urandom_range(h - 2);
          c = $urandom_range(2, w - 1);
          feed(r * w + c, style);
          settle();
          n = $urandom_range(c);
          write_reg(ipns_pkg::REG_FRAME_WIDTH, n);
          feed((h - r - 1) * ((n < ipns_pkg::MIN_DIM) ? ipns_pkg::MIN_DIM : n), style);
        end
        SEG_THRESH_CHANGE: begin
          n = $urandom_range(1, w * h - 1);
          feed(n, style);
          settle();
          write_reg(ipns_pkg::REG_DIFF_THRESHOLD, $urandom_range(255));
          feed(w * h - n, style);
        end
        default: feed(w * h, style);
      endcase
      settle();
    end

    settle();
    $display("Checked %0d results from %0d pixel items: a directed set and %0d random segments.",
             results_seen, pixels_taken, seg);
    $display("%0d register writes covered clamped and extreme geometry and mid-frame changes.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("isolated_pixel_neighbor_smoother test passed");
    end else begin
      $display("isolated_pixel_neighbor_smoother test failed");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("Timed out with %0d results still due.", smoothed_due.size());
    $display("isolated_pixel_neighbor_smoother test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ipns_pkg.sv
rtl/ipns_if.sv
rtl/ipns_ram.sv
rtl/ipns_front.sv
rtl/ipns_fifo.sv
rtl/ipns_back.sv
rtl/isolated_pixel_neighbor_smoother.sv
tb/isolated_pixel_neighbor_smoother_test.sv
